// ----- rtl/core/pressure_count_linearizer_defines.svh -----
// Assertion macros shared by the linearizer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PRESSURE_COUNT_LINEARIZER_DEFINES_SVH
`define PRESSURE_COUNT_LINEARIZER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PCL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcl: same-cycle check failed");

// Checks that the consequent holds a fixed number of cycles after the antecedent.
`define PCL_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("pcl: delayed check failed");

`endif

// ----- rtl/core/pcl_pkg.sv -----
package pcl_pkg;

    localparam int TABLE_POINTS = 12;
    localparam int SEG_W        = $clog2(TABLE_POINTS);
    localparam int COUNT_W      = 16;
    localparam int UTORR_W      = 30;
    localparam int X_W          = COUNT_W + 2;
    localparam int DP_W         = UTORR_W + 1;
    localparam int PROD_W       = X_W + DP_W;
    localparam int NUM_W        = PROD_W - 1;
    localparam int DEN_W        = COUNT_W;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int NUM_PAD_W    = DIV_STAGES * DIV_STEP;
    localparam int P_W          = 36;
    localparam int OUT_W        = 33;
    localparam int RANGE_W      = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;
    localparam int OT_W         = 11;
    localparam int OM_W         = 15;
    localparam int COARSE_W     = 31;
    localparam int FINE_W       = 25;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_TORR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_MTORR = 2'd2;

    localparam logic [COUNT_W-1:0] KNEE_COUNTS                = 16'd50000;
    localparam logic [UTORR_W-1:0] KNEE_UTORR                 = 30'd50000000;
    localparam logic [UTORR_W-1:0] UTORR_PER_MICRON           = 30'd1000;
    localparam logic [UTORR_W-1:0] UTORR_PER_COUNT_ABOVE_KNEE = 30'd45700;

    localparam logic signed [OT_W-1:0]     OFS_TORR_MAX   = 11'sd700;
    localparam logic signed [OM_W-1:0]     OFS_MTORR_MAX  = 15'sd10000;
    localparam logic signed [COARSE_W-1:0] UTORR_PER_TORR = 31'sd1000000;
    localparam logic signed [FINE_W-1:0]   UTORR_PER_MTORR = 25'sd1000;

    localparam logic signed [P_W-1:0] THRESHOLD_UTORR  = 36'sd10000000;
    localparam logic signed [P_W-1:0] SAT_UTORR        = 36'sd8000000000;
    localparam logic signed [P_W-1:0] RANGE_HIGH_UTORR = 36'sd100000000;
    localparam logic signed [P_W-1:0] RANGE_MID_UTORR  = 36'sd1000000;

    localparam logic [COUNT_W-1:0] CAL_COUNT [TABLE_POINTS] = '{
        16'd18836, 16'd21012, 16'd21916, 16'd24386, 16'd25868, 16'd27390,
        16'd28354, 16'd29279, 16'd30015, 16'd30556, 16'd30777, 16'd31484
    };

    localparam logic [UTORR_W-1:0] CAL_UTORR [TABLE_POINTS] = '{
        30'd760000000, 30'd28900000, 30'd18700000, 30'd8570000,
        30'd5940000,   30'd4140000,  30'd3390000,  30'd2770000,
        30'd2380000,   30'd2080000,  30'd1970000,  30'd1700000
    };

    typedef enum logic [RANGE_W-1:0] {
        RANGE_HIGH = 2'd0,
        RANGE_MID  = 2'd1,
        RANGE_LOW  = 2'd2
    } range_t;

    typedef struct packed {
        logic               use_q;
        logic               neg;
        logic [UTORR_W-1:0] base;
    } div_side_t;

endpackage

// ----- rtl/core/pressure_count_linearizer.sv -----
// Throughput: one beat per clock; busy stays low, so start may be high in every cycle.
// A result passes through stages 1 to 3, the divider, and stages A, B and C before it is on done.
// The depth is set by the twelve-stage radix-16 restoring divider used by the table mode.
// rst_n clears the configuration registers and every pipeline valid bit at once.
// Results cannot be held off, so the pipeline advances on every clock.
`include "pressure_count_linearizer_defines.svh"

module pressure_count_linearizer
    import pcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [COUNT_W-1:0]    factory_count,
    input  logic [COUNT_W-1:0]    raw_count,
    output logic                  done,
    output logic [OUT_W-1:0]      pressure_utorr,
    output logic [RANGE_W-1:0]    display_range
);

    localparam int PIPE_DEPTH = DIV_STAGES + 7;

    logic                       cal_mode_reg;
    logic signed [COARSE_W-1:0] ofs_coarse_reg;
    logic signed [COARSE_W-1:0] ofs_coarse_next;
    logic signed [FINE_W-1:0]   ofs_fine_reg;
    logic signed [FINE_W-1:0]   ofs_fine_next;
    logic signed [OT_W-1:0]     ot_raw;
    logic signed [OT_W-1:0]     ot_cl;
    logic signed [OM_W-1:0]     om_raw;
    logic signed [OM_W-1:0]     om_cl;

    logic                 s1_valid_reg;
    logic [COUNT_W-1:0]   s1_raw_reg;
    logic [SEG_W-1:0]     s1_seg_reg;
    logic [SEG_W-1:0]     s1_seg_next;
    logic [UTORR_W-1:0]   s1_fac_reg;
    logic [UTORR_W-1:0]   s1_fac_next;

    logic                    s2_valid_reg;
    logic signed [X_W-1:0]   s2_x_reg;
    logic signed [X_W-1:0]   s2_x_next;
    logic signed [DP_W-1:0]  s2_dp_reg;
    logic signed [DP_W-1:0]  s2_dp_next;
    logic [DEN_W-1:0]        s2_den_reg;
    logic [DEN_W-1:0]        s2_den_next;
    div_side_t               s2_side_reg;
    div_side_t               s2_side_next;
    logic [COUNT_W-1:0]      seg_r0;
    logic [COUNT_W-1:0]      seg_r1;
    logic [UTORR_W-1:0]      seg_p0;
    logic [UTORR_W-1:0]      seg_p1;

    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic [DEN_W-1:0]         s3_den_reg;
    div_side_t                s3_side_reg;

    logic                 div_valid_reg [DIV_STAGES+1];
    logic [NUM_PAD_W-1:0] div_num_reg   [DIV_STAGES+1];
    logic [DEN_W-1:0]     div_rem_reg   [DIV_STAGES+1];
    logic [DEN_W-1:0]     div_den_reg   [DIV_STAGES+1];
    div_side_t            div_side_reg  [DIV_STAGES+1];
    logic                 s4_neg_next;
    logic [NUM_W-1:0]     s4_mag_next;

    logic                  sa_valid_reg;
    logic signed [P_W-1:0] sa_p_reg;
    logic signed [P_W-1:0] sa_p_next;
    logic signed [P_W-1:0] sa_q;
    div_side_t             sa_side;

    logic                  sb_valid_reg;
    logic signed [P_W-1:0] sb_p_reg;
    logic signed [P_W-1:0] sb_p_next;

    logic                  done_reg;
    logic [OUT_W-1:0]      pressure_reg;
    logic [OUT_W-1:0]      pressure_next;
    range_t                range_reg;
    range_t                range_next;

    assign busy = 1'b0;

    // Offsets are clamped and scaled to micro-Torr when written.
    always_comb
    begin
        ot_raw = $signed(cfg_data[OT_W-1:0]);
        om_raw = $signed(cfg_data[OM_W-1:0]);
        if (ot_raw > OFS_TORR_MAX)
            ot_cl = OFS_TORR_MAX;
        else if (ot_raw < -OFS_TORR_MAX)
            ot_cl = -OFS_TORR_MAX;
        else
            ot_cl = ot_raw;
        if (om_raw > OFS_MTORR_MAX)
            om_cl = OFS_MTORR_MAX;
        else if (om_raw < -OFS_MTORR_MAX)
            om_cl = -OFS_MTORR_MAX;
        else
            om_cl = om_raw;
        ofs_coarse_next = COARSE_W'(ot_cl) * UTORR_PER_TORR;
        ofs_fine_next   = FINE_W'(om_cl) * UTORR_PER_MTORR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_mode_reg   <= 1'b0;
            ofs_coarse_reg <= '0;
            ofs_fine_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      cal_mode_reg   <= cfg_data[0];
                REG_OFS_TORR:  ofs_coarse_reg <= ofs_coarse_next;
                REG_OFS_MTORR: ofs_fine_reg   <= ofs_fine_next;
                default:       ;
            endcase
        end
    end

    // Stage 1: segment search and the factory formula.
    always_comb
    begin
        s1_seg_next = SEG_W'(TABLE_POINTS - 1);
        for (int k = TABLE_POINTS - 2; k >= 1; k--)
        begin
            if (raw_count < CAL_COUNT[k])
                s1_seg_next = SEG_W'(k);
        end
        if (factory_count > KNEE_COUNTS)
            s1_fac_next = KNEE_UTORR + UTORR_W'(factory_count - KNEE_COUNTS)
                          * UTORR_PER_COUNT_ABOVE_KNEE;
        else
            s1_fac_next = UTORR_W'(factory_count) * UTORR_PER_MICRON;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_raw_reg <= raw_count;
        s1_seg_reg <= s1_seg_next;
        s1_fac_reg <= s1_fac_next;
    end

    // Stage 2: segment end points, offset into the segment and slope terms.
    always_comb
    begin
        seg_r0 = CAL_COUNT[s1_seg_reg - SEG_W'(1)];
        seg_r1 = CAL_COUNT[s1_seg_reg];
        seg_p0 = CAL_UTORR[s1_seg_reg - SEG_W'(1)];
        seg_p1 = CAL_UTORR[s1_seg_reg];
        s2_x_next    = $signed({2'b00, s1_raw_reg}) - $signed({2'b00, seg_r0});
        s2_dp_next   = $signed({1'b0, seg_p1}) - $signed({1'b0, seg_p0});
        s2_den_next  = seg_r1 - seg_r0;
        s2_side_next.use_q = cal_mode_reg && (seg_r1 != seg_r0);
        s2_side_next.neg   = 1'b0;
        s2_side_next.base  = cal_mode_reg ? seg_p0 : s1_fac_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg    <= s2_x_next;
        s2_dp_reg   <= s2_dp_next;
        s2_den_reg  <= s2_den_next;
        s2_side_reg <= s2_side_next;
    end

    // Stage 3: the interpolation product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_prod_reg <= PROD_W'(s2_x_reg) * PROD_W'(s2_dp_reg);
        s3_den_reg  <= s2_den_reg;
        s3_side_reg <= s2_side_reg;
    end

    // Stage 4: the divider works on the magnitude; the quotient is negated later,
    // which truncates toward zero.
    always_comb
    begin
        s4_neg_next = s3_prod_reg[PROD_W-1];
        s4_mag_next = s4_neg_next ? NUM_W'(-s3_prod_reg) : NUM_W'(s3_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_valid_reg[0] <= 1'b0;
        else
            div_valid_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        div_num_reg[0]        <= NUM_PAD_W'(s4_mag_next);
        div_rem_reg[0]        <= '0;
        div_den_reg[0]        <= s3_den_reg;
        div_side_reg[0].use_q <= s3_side_reg.use_q;
        div_side_reg[0].neg   <= s4_neg_next;
        div_side_reg[0].base  <= s3_side_reg.base;
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [NUM_PAD_W-1:0] num_next;
        logic [DEN_W-1:0]     rem_next;

        always_comb
        begin
            logic [DEN_W:0]       trial;
            logic [DEN_W-1:0]     rem;
            logic [NUM_PAD_W-1:0] num;
            rem = div_rem_reg[g];
            num = div_num_reg[g];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                trial = {rem, num[NUM_PAD_W-1]};
                num   = {num[NUM_PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, div_den_reg[g]})
                begin
                    rem    = DEN_W'(trial - {1'b0, div_den_reg[g]});
                    num[0] = 1'b1;
                end
                else
                begin
                    rem = trial[DEN_W-1:0];
                end
            end
            rem_next = rem;
            num_next = num;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[g+1] <= 1'b0;
            else
                div_valid_reg[g+1] <= div_valid_reg[g];
        end

        always_ff @(posedge clk)
        begin
            div_num_reg[g+1]  <= num_next;
            div_rem_reg[g+1]  <= rem_next;
            div_den_reg[g+1]  <= div_den_reg[g];
            div_side_reg[g+1] <= div_side_reg[g];
        end
    end

    // Stage A: base point plus signed quotient.
    always_comb
    begin
        sa_side   = div_side_reg[DIV_STAGES];
        sa_q      = $signed(div_num_reg[DIV_STAGES][P_W-1:0]);
        sa_p_next = $signed({{(P_W - UTORR_W){1'b0}}, sa_side.base})
                    + (sa_side.use_q ? (sa_side.neg ? -sa_q : sa_q) : P_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_valid_reg <= 1'b0;
        else
            sa_valid_reg <= div_valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        sa_p_reg <= sa_p_next;
    end

    // Stage B: coarse offset above ten Torr, fine offset at or below it.
    always_comb
    begin
        if (sa_p_reg > THRESHOLD_UTORR)
            sb_p_next = sa_p_reg + P_W'(ofs_coarse_reg);
        else
            sb_p_next = sa_p_reg + P_W'(ofs_fine_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_valid_reg <= 1'b0;
        else
            sb_valid_reg <= sa_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sb_p_reg <= sb_p_next;
    end

    // Stage C: clamp, saturate and classify.
    always_comb
    begin
        if (sb_p_reg[P_W-1])
            pressure_next = '0;
        else if (sb_p_reg > SAT_UTORR)
            pressure_next = SAT_UTORR[OUT_W-1:0];
        else
            pressure_next = sb_p_reg[OUT_W-1:0];
        if (sb_p_reg > RANGE_HIGH_UTORR)
            range_next = RANGE_HIGH;
        else if (sb_p_reg >= RANGE_MID_UTORR)
            range_next = RANGE_MID;
        else
            range_next = RANGE_LOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        pressure_reg <= pressure_next;
        range_reg    <= range_next;
    end

    assign done           = done_reg;
    assign pressure_utorr = pressure_reg;
    assign display_range  = range_reg;

    `PCL_ASSERT_DELAY(a_latency, start && !busy, PIPE_DEPTH, done)
    `PCL_ASSERT_IMPL(a_no_spurious, done, $past(start, PIPE_DEPTH))
    `PCL_ASSERT_IMPL(a_sat, done, pressure_utorr <= SAT_UTORR[OUT_W-1:0])
    `PCL_ASSERT_IMPL(a_range, done, (display_range == RANGE_LOW) == (pressure_utorr < RANGE_MID_UTORR[OUT_W-1:0]))
    `PCL_ASSERT_IMPL(a_div_rem, div_valid_reg[DIV_STAGES] && div_side_reg[DIV_STAGES].use_q, div_rem_reg[DIV_STAGES] < div_den_reg[DIV_STAGES])

endmodule

// ----- dv/tb_pressure_count_linearizer.sv -----
module tb_pressure_count_linearizer;
    timeunit 1ns;
    timeprecision 1ps;
    import pcl_pkg::*;

    localparam int     TBL_N            = 12;
    localparam longint KNEE             = 50000;
    localparam longint UT_PER_MICRON    = 1000;
    localparam longint UT_PER_COUNT_HI  = 45700;
    localparam longint OFS_SWITCH_UTORR = 10000000;
    localparam longint TORR_CLAMP       = 700;
    localparam longint MTORR_CLAMP      = 10000;
    localparam longint UT_PER_TORR      = 1000000;
    localparam longint UT_PER_MTORR     = 1000;
    localparam longint CEILING_UTORR    = 64'sd8000000000;
    localparam longint HIGH_EDGE_UTORR  = 100000000;
    localparam longint MID_EDGE_UTORR   = 1000000;
    localparam int     STALL_LIMIT      = 3000;
    localparam int     DRAIN_CYCLES     = 25;
    localparam int     RANDOM_PHASES    = 10;
    localparam int     PHASE_SAMPLES    = 110;
    localparam int     QUIET_PHASE      = 4;

    typedef struct packed {
        logic [15:0] fac;
        logic [15:0] raw;
    } sample_t;

    typedef struct packed {
        logic [32:0] utorr;
        range_t      rng;
    } reading_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COUNT_W-1:0]    factory_count = '0;
    logic [COUNT_W-1:0]    raw_count = '0;
    logic                  done;
    logic [OUT_W-1:0]      pressure_utorr;
    logic [RANGE_W-1:0]    display_range;

    pressure_count_linearizer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .factory_count  (factory_count),
        .raw_count      (raw_count),
        .done           (done),
        .pressure_utorr (pressure_utorr),
        .display_range  (display_range)
    );

    sample_t  sample_q[$];
    reading_t reading_q[$];
    reading_t head;
    sample_t  next_sample;
    longint   knot_count [TBL_N];
    longint   knot_utorr [TBL_N];
    logic              mode_now = 1'b0;
    logic signed [10:0] ofs_torr_now = '0;
    logic signed [14:0] ofs_mtorr_now = '0;
    logic     gaps_on = 1'b1;
    logic     beat_taken = 1'b0;
    int       samples_queued = 0;
    int       samples_taken = 0;
    int       mismatches = 0;
    int       stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic reading_t predict_reading(input logic [15:0] fac_in,
                                                 input logic [15:0] raw_in);
        reading_t res;
        longint   fac;
        longint   raw;
        longint   p;
        longint   ot;
        longint   om;
        longint   den;
        int       seg;
        fac = fac_in;
        raw = raw_in;
        if (mode_now)
        begin
            seg = 1;
            while (seg < TBL_N - 1 && raw >= knot_count[seg])
                seg++;
            den = knot_count[seg] - knot_count[seg-1];
            if (den == 0)
                p = knot_utorr[seg-1];
            else
                p = knot_utorr[seg-1] + ((knot_utorr[seg] - knot_utorr[seg-1])
                    * (raw - knot_count[seg-1])) / den;
        end
        else if (fac > KNEE)
            p = KNEE * UT_PER_MICRON + (fac - KNEE) * UT_PER_COUNT_HI;
        else
            p = fac * UT_PER_MICRON;
        ot = ofs_torr_now;
        om = ofs_mtorr_now;
        if (ot > TORR_CLAMP) ot = TORR_CLAMP;
        if (ot < -TORR_CLAMP) ot = -TORR_CLAMP;
        if (om > MTORR_CLAMP) om = MTORR_CLAMP;
        if (om < -MTORR_CLAMP) om = -MTORR_CLAMP;
        if (p > OFS_SWITCH_UTORR)
            p = p + ot * UT_PER_TORR;
        else
            p = p + om * UT_PER_MTORR;
        if (p < 0) p = 0;
        if (p > CEILING_UTORR) p = CEILING_UTORR;
        res.utorr = p[32:0];
        if (p > HIGH_EDGE_UTORR)
            res.rng = RANGE_HIGH;
        else if (p >= MID_EDGE_UTORR)
            res.rng = RANGE_MID;
        else
            res.rng = RANGE_LOW;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MODE:      mode_now = val[0];
            REG_OFS_TORR:  ofs_torr_now = val[10:0];
            REG_OFS_MTORR: ofs_mtorr_now = val[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_calibration(input logic mode, input logic signed [10:0] torr,
                                   input logic signed [14:0] mtorr);
        write_reg(REG_MODE, {14'($urandom), mode});
        write_reg(REG_OFS_TORR, {4'($urandom), torr});
        write_reg(REG_OFS_MTORR, mtorr);
    endtask

    task automatic queue_sample(input logic [15:0] fac, input logic [15:0] raw);
        sample_q.push_back('{fac: fac, raw: raw});
        samples_queued++;
    endtask

    task automatic drain_pipeline();
        while (!(samples_taken == samples_queued && reading_q.size() == 0))
            @(posedge clk);
    endtask

    function automatic logic signed [10:0] pick_torr();
        case ($urandom_range(0, 3))
            0: return 11'sd700;
            1: return -11'sd700;
            2: return $urandom_range(0, 1) ? 11'($urandom_range(701, 1023))
                                           : -11'($urandom_range(701, 1024));
            default: return 11'($urandom_range(0, 1400)) - 11'sd700;
        endcase
    endfunction

    function automatic logic signed [14:0] pick_mtorr();
        case ($urandom_range(0, 3))
            0: return 15'sd10000;
            1: return -15'sd10000;
            2: return $urandom_range(0, 1) ? 15'($urandom_range(10001, 16383))
                                           : -15'($urandom_range(10001, 16384));
            default: return 15'($urandom_range(0, 20000)) - 15'sd10000;
        endcase
    endfunction

    function automatic logic [15:0] pick_factory();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 12000));
            2: return 16'($urandom_range(48000, 53000));
            default: return 16'($urandom_range(9900, 10100));
        endcase
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(18000, 32000));
            2: return 16'($urandom_range(31000, 37000));
            default: return 16'($urandom_range(0, 18836));
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || beat_taken)
        begin
            if (sample_q.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 17))
            begin
                next_sample = sample_q.pop_front();
                start <= 1'b1;
                factory_count <= next_sample.fac;
                raw_count <= next_sample.raw;
            end
            else
            begin
                start <= 1'b0;
                factory_count <= 16'($urandom);
                raw_count <= 16'($urandom);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                reading_q.push_back(predict_reading(factory_count, raw_count));
                samples_taken++;
            end
            if (done)
            begin
                if (reading_q.size() == 0)
                    report_mismatch("result beat with nothing pending", pressure_utorr, 0);
                else
                begin
                    head = reading_q.pop_front();
                    if (pressure_utorr !== head.utorr)
                        report_mismatch("pressure_utorr", pressure_utorr, head.utorr);
                    if (display_range !== head.rng)
                        report_mismatch("display_range", display_range, head.rng);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", reading_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        knot_count = '{18836, 21012, 21916, 24386, 25868, 27390,
                       28354, 29279, 30015, 30556, 30777, 31484};
        knot_utorr = '{760000000, 28900000, 18700000, 8570000, 5940000, 4140000,
                       3390000, 2770000, 2380000, 2080000, 1970000, 1700000};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_sample(16'd0, 16'hFFFF);
        queue_sample(16'd999, 16'd0);
        queue_sample(16'd1000, 16'd0);
        queue_sample(16'd10000, 16'd0);
        queue_sample(16'd10001, 16'd0);
        queue_sample(16'd50000, 16'd0);
        queue_sample(16'd50001, 16'd0);
        queue_sample(16'hFFFF, 16'd0);
        drain_pipeline();

        set_calibration(1'b1, 11'sd700, -15'sd10000);
        queue_sample(16'hFFFF, 16'd0);
        queue_sample(16'd0, 16'd18835);
        queue_sample(16'd0, 16'd18836);
        queue_sample(16'd0, 16'd21012);
        queue_sample(16'd0, 16'd25000);
        queue_sample(16'd0, 16'd31483);
        queue_sample(16'd0, 16'd31484);
        queue_sample(16'd0, 16'd34000);
        queue_sample(16'd0, 16'hFFFF);
        drain_pipeline();

        set_calibration(1'b0, -11'sd1024, 15'sd16383);
        queue_sample(16'd10000, 16'hFFFF);
        queue_sample(16'd10001, 16'hFFFF);
        queue_sample(16'd0, 16'hFFFF);
        queue_sample(16'hFFFF, 16'hFFFF);
        drain_pipeline();

        set_calibration(1'b0, 11'sd1023, -15'sd16384);
        queue_sample(16'd10000, 16'd0);
        queue_sample(16'd20000, 16'd0);
        queue_sample(16'd5000, 16'd0);
        drain_pipeline();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_calibration(1'($urandom), pick_torr(), pick_mtorr());
            gaps_on = (ph != QUIET_PHASE);
            for (int n = 0; n < PHASE_SAMPLES; n++)
                queue_sample(pick_factory(), pick_raw());
            drain_pipeline();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
